// File: sv/thpc_pkg.sv
// ---------------------------------------------------------------------------
// thpc_pkg
// Shared widths, register indexes and constants of the sensor compensation.
// ---------------------------------------------------------------------------
package thpc_pkg;

  localparam int WORD_W      = 64;
  localparam int HALF_W      = 32;
  localparam int MUL_LAT     = 2;
  localparam int DIV_LAT     = WORD_W + 2;
  localparam int PIPE_LAT    = 89;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 88;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CAL_LO   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_MID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_HIGH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_HUM  = 2'd3;

  localparam logic [63:0] TF_OFS_P     = 64'd128000;
  localparam logic [31:0] TF_OFS_H     = 32'd76800;
  localparam logic [31:0] HUM_MAX      = 32'd419430400;
  localparam logic [20:0] P_BASE       = 21'd1048576;
  localparam logic [63:0] P_SCALE      = 64'd3125;
  localparam logic [31:0] HD_BIAS      = 32'd2097152;
  localparam logic [31:0] HA_RND       = 32'd16384;
  localparam logic [31:0] HC_BIAS      = 32'd32768;
  localparam logic [31:0] HE_RND       = 32'd8192;
  localparam logic [31:0] DIV100_MAGIC = 32'h51EB851F;
  localparam int          DIV100_SH    = 37;

endpackage

// File: sv/thpc_mul64.sv
// ---------------------------------------------------------------------------
// thpc_mul64
// Two-stage low-half 64x64 multiplier built from 32x32 partial products.
// ---------------------------------------------------------------------------
module thpc_mul64 (
  input  logic                        clk,
  input  logic                        en,
  input  logic [thpc_pkg::WORD_W-1:0] a_i,
  input  logic [thpc_pkg::WORD_W-1:0] b_i,
  output logic [thpc_pkg::WORD_W-1:0] p_o
);

  localparam int H = thpc_pkg::HALF_W;

  logic [thpc_pkg::WORD_W-1:0] ll_r;
  logic [H-1:0]                lh_r;
  logic [H-1:0]                hl_r;
  logic [thpc_pkg::WORD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= {{H{1'b0}}, a_i[H-1:0]} * {{H{1'b0}}, b_i[H-1:0]};
      lh_r <= a_i[H-1:0] * b_i[2*H-1:H];
      hl_r <= a_i[2*H-1:H] * b_i[H-1:0];
      p_r  <= ll_r + {lh_r + hl_r, {H{1'b0}}};
    end
  end

  assign p_o = p_r;

endmodule

// File: sv/thpc_div64.sv
// ---------------------------------------------------------------------------
// thpc_div64
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
// ---------------------------------------------------------------------------
module thpc_div64 (
  input  logic                        clk,
  input  logic                        en,
  input  logic [thpc_pkg::WORD_W-1:0] num_i,
  input  logic [thpc_pkg::WORD_W-1:0] den_i,
  output logic [thpc_pkg::WORD_W-1:0] quo_o
);

  localparam int W = thpc_pkg::WORD_W;

  logic [W-1:0] rem_r [W+1];
  logic [W-1:0] quo_r [W+1];
  logic [W-1:0] den_r [W+1];
  logic         neg_r [W+1];
  logic [W-1:0] res_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      quo_r[0] <= num_i[W-1] ? (~num_i + 1'b1) : num_i;
      den_r[0] <= den_i[W-1] ? (~den_i + 1'b1) : den_i;
      neg_r[0] <= num_i[W-1] ^ den_i[W-1];
      res_r    <= neg_r[W] ? (~quo_r[W] + 1'b1) : quo_r[W];
    end
  end

  for (genvar i = 0; i < W; i++) begin : g_step
    logic [W:0] trial_nxt;
    logic       ge_nxt;
    logic [W:0] diff_nxt;

    always_comb begin
      trial_nxt = {rem_r[i], quo_r[i][W-1]};
      diff_nxt  = trial_nxt - {1'b0, den_r[i]};
      ge_nxt    = trial_nxt >= {1'b0, den_r[i]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= ge_nxt ? diff_nxt[W-1:0] : trial_nxt[W-1:0];
        quo_r[i+1] <= {quo_r[i][W-2:0], ge_nxt};
        den_r[i+1] <= den_r[i];
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  assign quo_o = res_r;

endmodule

// File: sv/thp_sensor_compensation.sv
// ---------------------------------------------------------------------------
// thp_sensor_compensation
// Integer temperature, pressure and humidity compensation of raw samples.
//
//   channel  dir  handshake          payload
//   in_      in   tvalid/tready      tdata: pressure, temperature, humidity
//   out_     out  tvalid/tready      tdata: temp, pressure, humidity; tuser
//   cfg_     in   we                 index, wdata: calibration bytes
//
// One item enters per cycle while the output is not stalled.
// Latency is set by the pressure divider plus the multiply chains.
// Reset clears the valid bits and the calibration registers.
// A stalled output freezes the whole pipeline; nothing is dropped.
// ---------------------------------------------------------------------------
module thp_sensor_compensation (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // raw_pressure[19:0], raw_temperature[39:20], raw_humidity[55:40]
  input  logic [thpc_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // temp_centi[31:0], pressure_scaled[63:32], humidity_q10[80:64], zero fill
  output logic [thpc_pkg::OUT_TDATA_W-1:0] out_tdata,
  // pressure_invalid[0]
  output logic                             out_tuser,
  input  logic                             cfg_we,
  input  logic [thpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [thpc_pkg::WORD_W-1:0]      cfg_wdata
);

  localparam int LAT      = thpc_pkg::PIPE_LAT;
  localparam int TEMP_DLY = 84;
  localparam int HUM_DLY  = 75;
  localparam int INV_DLY  = 74;

  logic [63:0] cal_lo_r, cal_mid_r, cal_high_r, cal_hum_r;
  logic [LAT-1:0] vld_r;
  logic pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_lo_r   <= '0;
      cal_mid_r  <= '0;
      cal_high_r <= '0;
      cal_hum_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        thpc_pkg::REG_CAL_LO:   cal_lo_r   <= cfg_wdata;
        thpc_pkg::REG_CAL_MID:  cal_mid_r  <= cfg_wdata;
        thpc_pkg::REG_CAL_HIGH: cal_high_r <= cfg_wdata;
        thpc_pkg::REG_CAL_HUM:  cal_hum_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign pipe_en    = !vld_r[LAT-1] || out_tready;
  assign in_tready  = pipe_en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  logic [31:0] t1_w, t2_w, t3_w, h1_w, h2_w, h3_w, h4_w, h5_w, h6_w;
  logic [63:0] p1_w, p2_w, p3_w, p4_w, p5_w, p6_w, p7_w, p8_w, p9_w;

  always_comb begin
    t1_w = {16'b0, cal_lo_r[15:0]};
    t2_w = {{16{cal_lo_r[31]}}, cal_lo_r[31:16]};
    t3_w = {{16{cal_lo_r[47]}}, cal_lo_r[47:32]};
    p1_w = {48'b0, cal_lo_r[63:48]};
    p2_w = {{48{cal_mid_r[15]}}, cal_mid_r[15:0]};
    p3_w = {{48{cal_mid_r[31]}}, cal_mid_r[31:16]};
    p4_w = {{48{cal_mid_r[47]}}, cal_mid_r[47:32]};
    p5_w = {{48{cal_mid_r[63]}}, cal_mid_r[63:48]};
    p6_w = {{48{cal_high_r[15]}}, cal_high_r[15:0]};
    p7_w = {{48{cal_high_r[31]}}, cal_high_r[31:16]};
    p8_w = {{48{cal_high_r[47]}}, cal_high_r[47:32]};
    p9_w = {{48{cal_high_r[63]}}, cal_high_r[63:48]};
    h1_w = {24'b0, cal_hum_r[7:0]};
    h2_w = {{16{cal_hum_r[23]}}, cal_hum_r[23:8]};
    h3_w = {24'b0, cal_hum_r[31:24]};
    h4_w = {{20{cal_hum_r[39]}}, cal_hum_r[39:32], cal_hum_r[43:40]};
    h5_w = {{20{cal_hum_r[55]}}, cal_hum_r[55:48], cal_hum_r[47:44]};
    h6_w = {{24{cal_hum_r[63]}}, cal_hum_r[63:56]};
  end

  // temperature
  logic [31:0] t32_nxt;
  logic [31:0] a_r, d_r, m1_r, dd_r, v1_r, m2_r, tf_r, temp_r, hv_r;
  logic [63:0] x1_r;
  logic [19:0] p_dl_r [12];
  logic [15:0] h_dl_r [6];

  assign t32_nxt = {12'b0, in_tdata[39:20]};

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      a_r    <= (t32_nxt >> 3) - (t1_w << 1);
      d_r    <= (t32_nxt >> 4) - t1_w;
      m1_r   <= a_r * t2_w;
      dd_r   <= d_r * d_r;
      v1_r   <= 32'($signed(m1_r) >>> 11);
      m2_r   <= 32'($signed(dd_r) >>> 12) * t3_w;
      tf_r   <= v1_r + 32'($signed(m2_r) >>> 14);
      temp_r <= 32'($signed(tf_r * 32'd5 + 32'd128) >>> 8);
      x1_r   <= {{32{tf_r[31]}}, tf_r} - thpc_pkg::TF_OFS_P;
      hv_r   <= tf_r - thpc_pkg::TF_OFS_H;
      p_dl_r[0] <= in_tdata[19:0];
      for (int i = 1; i < 12; i++) p_dl_r[i] <= p_dl_r[i-1];
      h_dl_r[0] <= in_tdata[55:40];
      for (int i = 1; i < 6; i++) h_dl_r[i] <= h_dl_r[i-1];
    end
  end

  // pressure, ahead of the divider
  logic [63:0] sq_w, x1p5_w, x1p2_w, x2a_w, y_w, xp1_w, num_w;
  logic [63:0] part_r, part2_r, x1p2s_r, x1p2s2_r, x2_r, xb_r, x2_11_r, x2_12_r;
  logic [63:0] x1c_r, x1c14_r, x1c15_r, diff_r;
  logic [20:0] pv_nxt;

  thpc_mul64 u_mul_sq (.clk, .en(pipe_en), .a_i(x1_r), .b_i(x1_r), .p_o(sq_w));
  thpc_mul64 u_mul_p5 (.clk, .en(pipe_en), .a_i(x1_r), .b_i(p5_w), .p_o(x1p5_w));
  thpc_mul64 u_mul_p2 (.clk, .en(pipe_en), .a_i(x1_r), .b_i(p2_w), .p_o(x1p2_w));
  thpc_mul64 u_mul_p6 (.clk, .en(pipe_en), .a_i(sq_w), .b_i(p6_w), .p_o(x2a_w));
  thpc_mul64 u_mul_p3 (.clk, .en(pipe_en), .a_i(sq_w), .b_i(p3_w), .p_o(y_w));
  thpc_mul64 u_mul_p1 (.clk, .en(pipe_en), .a_i(xb_r), .b_i(p1_w), .p_o(xp1_w));
  thpc_mul64 u_mul_k  (.clk, .en(pipe_en), .a_i(diff_r), .b_i(thpc_pkg::P_SCALE),
                       .p_o(num_w));

  assign pv_nxt = thpc_pkg::P_BASE - {1'b0, p_dl_r[11]};

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      part_r   <= (x1p5_w << 17) + (p4_w << 35);
      x1p2s_r  <= x1p2_w << 12;
      part2_r  <= part_r;
      x1p2s2_r <= x1p2s_r;
      x2_r     <= x2a_w + part2_r;
      xb_r     <= 64'($signed(y_w) >>> 8) + x1p2s2_r + (64'd1 << 47);
      x2_11_r  <= x2_r;
      x2_12_r  <= x2_11_r;
      x1c_r    <= 64'($signed(xp1_w) >>> 33);
      diff_r   <= ({43'b0, pv_nxt} << 31) - x2_12_r;
      x1c14_r  <= x1c_r;
      x1c15_r  <= x1c14_r;
    end
  end

  // pressure, divider and after
  logic [63:0] q_w, s_nxt, ss_w, y2_w, y1_w;
  logic [63:0] q_dl_r [4];
  logic [63:0] y2a_r, y2b_r, sum_r, res_nxt, prod_r;
  logic [31:0] lo_nxt, mag_r, pres_r, pq_nxt;
  logic        neg_r, neg2_r;
  logic        inval_dl_r [INV_DLY];

  thpc_div64 u_div (.clk, .en(pipe_en), .num_i(num_w), .den_i(x1c15_r), .quo_o(q_w));

  assign s_nxt = 64'($signed(q_w) >>> 13);

  thpc_mul64 u_mul_ss (.clk, .en(pipe_en), .a_i(s_nxt), .b_i(s_nxt), .p_o(ss_w));
  thpc_mul64 u_mul_p8 (.clk, .en(pipe_en), .a_i(q_w), .b_i(p8_w), .p_o(y2_w));
  thpc_mul64 u_mul_p9 (.clk, .en(pipe_en), .a_i(ss_w), .b_i(p9_w), .p_o(y1_w));

  always_comb begin
    res_nxt = 64'($signed(sum_r) >>> 8) + (p7_w << 4);
    lo_nxt  = res_nxt[31:0];
    pq_nxt  = {5'b0, prod_r[thpc_pkg::DIV100_SH+26:thpc_pkg::DIV100_SH]};
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      q_dl_r[0] <= q_w;
      for (int i = 1; i < 4; i++) q_dl_r[i] <= q_dl_r[i-1];
      y2a_r  <= y2_w;
      y2b_r  <= y2a_r;
      sum_r  <= q_dl_r[3] + 64'($signed(y1_w) >>> 25) + 64'($signed(y2b_r) >>> 19);
      neg_r  <= lo_nxt[31];
      mag_r  <= lo_nxt[31] ? (~lo_nxt + 1'b1) : lo_nxt;
      prod_r <= {32'b0, mag_r} * {32'b0, thpc_pkg::DIV100_MAGIC};
      neg2_r <= neg_r;
      pres_r <= inval_dl_r[INV_DLY-2] ? '0 : (neg2_r ? (~pq_nxt + 1'b1) : pq_nxt);
      inval_dl_r[0] <= (x1c15_r == '0);
      for (int i = 1; i < INV_DLY; i++) inval_dl_r[i] <= inval_dl_r[i-1];
    end
  end

  // humidity
  logic [31:0] ma_r, mb_r, mc_r, ha_r, hb_r, hc_r, hbc_r, ha8_r, md_r, ha9_r;
  logic [31:0] he_r, ha10_r, hv2_r, qq_r, hv2_12_r, me_r, hv2_13_r, hf_nxt;
  logic [16:0] hum_r;
  logic [16:0] hum_dl_r [HUM_DLY];
  logic [31:0] temp_dl_r [TEMP_DLY];

  assign hf_nxt = hv2_13_r - 32'($signed(me_r) >>> 4);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      ma_r     <= h5_w * hv_r;
      mb_r     <= hv_r * h6_w;
      mc_r     <= hv_r * h3_w;
      ha_r     <= 32'($signed(({16'b0, h_dl_r[5]} << 14) - (h4_w << 20) - ma_r
                  + thpc_pkg::HA_RND) >>> 15);
      hb_r     <= 32'($signed(mb_r) >>> 10);
      hc_r     <= 32'($signed(mc_r) >>> 11) + thpc_pkg::HC_BIAS;
      hbc_r    <= hb_r * hc_r;
      ha8_r    <= ha_r;
      md_r     <= (32'($signed(hbc_r) >>> 10) + thpc_pkg::HD_BIAS) * h2_w;
      ha9_r    <= ha8_r;
      he_r     <= 32'($signed(md_r + thpc_pkg::HE_RND) >>> 14);
      ha10_r   <= ha9_r;
      hv2_r    <= ha10_r * he_r;
      qq_r     <= 32'($signed(hv2_r) >>> 15) * 32'($signed(hv2_r) >>> 15);
      hv2_12_r <= hv2_r;
      me_r     <= 32'($signed(qq_r) >>> 7) * h1_w;
      hv2_13_r <= hv2_12_r;
      if (hf_nxt[31]) begin
        hum_r <= '0;
      end else if (hf_nxt > thpc_pkg::HUM_MAX) begin
        hum_r <= thpc_pkg::HUM_MAX[28:12];
      end else begin
        hum_r <= hf_nxt[28:12];
      end
      hum_dl_r[0] <= hum_r;
      for (int i = 1; i < HUM_DLY; i++) hum_dl_r[i] <= hum_dl_r[i-1];
      temp_dl_r[0] <= temp_r;
      for (int i = 1; i < TEMP_DLY; i++) temp_dl_r[i] <= temp_dl_r[i-1];
    end
  end

  assign out_tdata = {7'b0, hum_dl_r[HUM_DLY-1], pres_r, temp_dl_r[TEMP_DLY-1]};
  assign out_tuser = inval_dl_r[INV_DLY-1];

`ifndef SYNTHESIS
  a_inval_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[63:32] == 32'd0)
    else $error("invalid pressure item carries nonzero pressure");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[80:64] <= 17'd102400)
    else $error("humidity above clamp");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output is empty");

  a_drop_only_on_take: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_tvalid) |-> $past(out_tready))
    else $error("result item dropped without handshake");
`endif

endmodule
